// ----- design/ptlb_pkg.sv -----
package ptlb_pkg;

  // sequencer phases: load, backward walk, final pops, emission
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_KRD,
    ST_KIND,
    ST_POP1,
    ST_POP2,
    ST_FIN0,
    ST_FIN1,
    ST_FIN2,
    ST_ERD,
    ST_ELOAD,
    ST_RLOAD
  } state_t;

  // node kind as held in the kind memory
  typedef enum logic [1:0] {
    KIND_EMPTY = 2'd0,
    KIND_LEAF  = 2'd1,
    KIND_INNER = 2'd2
  } kind_t;

  // bit that flags the main root in the decoded parent value
  localparam int unsigned ROOT_BIT = 4;

  typedef struct packed {
    logic [3:0] node_index;
    logic [3:0] parent_index;
    logic       parent_is_root;
    logic [3:0] left_child;
    logic [3:0] right_child;
    logic       is_leaf;
    logic       is_root_entry;
    logic       malformed;
    logic       last;
  } res_t;

endpackage

// ----- design/preorder_tree_link_builder.sv -----
// channel  | direction | ports                                         | request
// ---------+-----------+-----------------------------------------------+------------------------
// in_      | input     | in_node_id, in_right_root_index, in_last_node | one preorder node
// out_     | output    | out_node_index .. out_last                    | one node's links or root
//
// loading accepts one request per cycle; after the request flagged last the tree is walked
// backwards: each node has its kind read and handled, and an inner node then pops its two
// children; then come the final root pops, a memory read and an output register load per
// node result, and a last load for the root entry
// rst_n is synchronous and clears the sequencer and counters, not the memories
// out_stall holds each output load; in_stall is high from the last node to the root entry load
module preorder_tree_link_builder #(
  parameter int MAX_NODES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_node_id,
  input  logic [3:0] in_right_root_index,
  input  logic       in_last_node,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_node_index,
  output logic [3:0] out_parent_index,
  output logic       out_parent_is_root,
  output logic [3:0] out_left_child,
  output logic [3:0] out_right_child,
  output logic       out_is_leaf,
  output logic       out_is_root_entry,
  output logic       out_malformed,
  output logic       out_last
);

  import ptlb_pkg::*;

  // index, count and packed word widths
  localparam int IW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int LW = 2 * IW + 1;   // link word: left, right, leaf
  localparam int PW = IW + 1;       // parent word: root mark, index
  localparam int VW = (IW > 5) ? IW : 5;

  // sequencer state
  state_t st_r, st_nxt;

  // control registers
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] dep_r, dep_nxt;
  logic          err_r, err_nxt;
  logic [3:0]    rr_r, rr_nxt;

  // payload registers
  logic [IW-1:0] i_r, i_nxt;
  logic [IW-1:0] c1_r, c1_nxt;
  logic [IW-1:0] rl_r, rl_nxt;
  logic [IW-1:0] rt_r, rt_nxt;
  logic [IW-1:0] e_r, e_nxt;

  // memory ports
  logic          kind_we, kind_re;
  logic [IW-1:0] kind_waddr;
  logic [1:0]    kind_wdata, kind_rd;
  logic          stk_we, stk_re;
  logic [IW-1:0] stk_waddr, stk_raddr, stk_rd;
  logic          lnk_we, lnk_re;
  logic [IW-1:0] lnk_waddr;
  logic [LW-1:0] lnk_wdata, lnk_rd;
  logic          par_we, par_re;
  logic [IW-1:0] par_waddr;
  logic [PW-1:0] par_wdata, par_rd;

  // output register
  logic out_load, out_can;
  res_t out_din, out_dout;

  // helpers
  logic          in_acc;
  kind_t         kind_q;
  logic          dep_pos, dep_gt1, e_last;
  logic [IW-1:0] top_addr, sec_addr;
  logic [CW-1:0] dep_dec;
  logic [VW-1:0] par_val;

  assign in_stall = (st_r != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign kind_q   = kind_t'(kind_rd);
  assign dep_pos  = (dep_r != '0);
  assign dep_gt1  = (dep_r > CW'(1));
  assign dep_dec  = dep_r - CW'(1);
  assign top_addr = IW'(dep_r - CW'(1));
  assign sec_addr = IW'(dep_r - CW'(2));
  assign e_last   = ((CW'(e_r) + CW'(1)) == cnt_r);

  // parent word decode: root mark reads as index sixteen
  assign par_val = par_rd[IW] ? VW'(16) : VW'(par_rd[IW-1:0]);

  // node kinds, one per loaded request
  ptlb_ram #(.WIDTH(2), .DEPTH(MAX_NODES)) u_kind_ram (
    .clk   (clk),
    .we    (kind_we),
    .waddr (kind_waddr),
    .wdata (kind_wdata),
    .re    (kind_re),
    .raddr (i_r),
    .rdata (kind_rd)
  );

  // index stack
  ptlb_ram #(.WIDTH(IW), .DEPTH(MAX_NODES)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (i_r),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rd)
  );

  // children and leaf flag per node
  ptlb_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_link_ram (
    .clk   (clk),
    .we    (lnk_we),
    .waddr (lnk_waddr),
    .wdata (lnk_wdata),
    .re    (lnk_re),
    .raddr (e_r),
    .rdata (lnk_rd)
  );

  // parent per node; each entry is cleared on its own visit before any link lands
  ptlb_ram #(.WIDTH(PW), .DEPTH(MAX_NODES)) u_parent_ram (
    .clk   (clk),
    .we    (par_we),
    .waddr (par_waddr),
    .wdata (par_wdata),
    .re    (par_re),
    .raddr (e_r),
    .rdata (par_rd)
  );

  ptlb_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (out_load),
    .din      (out_din),
    .stall    (out_stall),
    .can_load (out_can),
    .valid    (out_valid),
    .dout     (out_dout)
  );

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_LOAD: begin
        if (in_acc && in_last_node) begin
          st_nxt = ST_KRD;
        end
      end
      ST_KRD: st_nxt = ST_KIND;
      ST_KIND: begin
        if (kind_q == KIND_INNER) begin
          st_nxt = ST_POP1;
        end else if (i_r == '0) begin
          st_nxt = ST_FIN0;
        end else begin
          st_nxt = ST_KRD;
        end
      end
      ST_POP1: st_nxt = ST_POP2;
      ST_POP2: st_nxt = (i_r == '0) ? ST_FIN0 : ST_KRD;
      ST_FIN0: st_nxt = ST_FIN1;
      ST_FIN1: st_nxt = ST_FIN2;
      ST_FIN2: st_nxt = ST_ERD;
      ST_ERD:  st_nxt = ST_ELOAD;
      ST_ELOAD: begin
        if (out_can) begin
          st_nxt = e_last ? ST_RLOAD : ST_ERD;
        end
      end
      ST_RLOAD: begin
        if (out_can) begin
          st_nxt = ST_LOAD;
        end
      end
      default: st_nxt = ST_LOAD;
    endcase
  end

  // datapath and memory control
  always_comb begin
    logic [CW-1:0] cnt_after;
    logic [CW-1:0] dep_pop;
    logic [IW-1:0] c2;

    cnt_nxt = cnt_r;
    dep_nxt = dep_r;
    err_nxt = err_r;
    rr_nxt  = rr_r;
    i_nxt   = i_r;
    c1_nxt  = c1_r;
    rl_nxt  = rl_r;
    rt_nxt  = rt_r;
    e_nxt   = e_r;

    kind_we    = 1'b0;
    kind_waddr = IW'(cnt_r);
    kind_wdata = KIND_EMPTY;
    kind_re    = 1'b0;
    stk_we     = 1'b0;
    stk_waddr  = IW'(dep_r);
    stk_re     = 1'b0;
    stk_raddr  = top_addr;
    lnk_we     = 1'b0;
    lnk_waddr  = i_r;
    lnk_wdata  = '0;
    lnk_re     = 1'b0;
    par_we     = 1'b0;
    par_waddr  = i_r;
    par_wdata  = '0;
    par_re     = 1'b0;
    out_load   = 1'b0;
    out_din    = '0;

    cnt_after = (cnt_r < CW'(MAX_NODES)) ? cnt_r + CW'(1) : cnt_r;
    dep_pop   = dep_pos ? dep_dec : dep_r;
    c2        = dep_pos ? stk_rd : '0;

    unique case (st_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (cnt_r < CW'(MAX_NODES)) begin
            kind_we = 1'b1;
            if (in_node_id == 8'd0) begin
              kind_wdata = KIND_EMPTY;
            end else if (in_node_id[7]) begin
              kind_wdata = KIND_INNER;
            end else begin
              kind_wdata = KIND_LEAF;
            end
            cnt_nxt = cnt_after;
          end else begin
            // beyond capacity: dropped
            err_nxt = 1'b1;
          end
          if (in_last_node) begin
            rr_nxt  = in_right_root_index;
            i_nxt   = IW'(cnt_after - CW'(1));
            dep_nxt = '0;
          end
        end
      end
      ST_KRD: begin
        kind_re = 1'b1;
      end
      ST_KIND: begin
        par_we = 1'b1;
        unique case (kind_q)
          KIND_LEAF: begin
            lnk_we    = 1'b1;
            lnk_wdata = LW'(1);
            if (dep_r < CW'(MAX_NODES)) begin
              stk_we  = 1'b1;
              dep_nxt = dep_r + CW'(1);
            end else begin
              err_nxt = 1'b1;
            end
            i_nxt = i_r - IW'(1);
          end
          KIND_INNER: begin
            stk_re = dep_pos;
          end
          default: begin
            // empty slot: no links
            lnk_we = 1'b1;
            i_nxt  = i_r - IW'(1);
          end
        endcase
      end
      ST_POP1: begin
        if (dep_pos) begin
          c1_nxt    = stk_rd;
          dep_nxt   = dep_dec;
          par_we    = 1'b1;
          par_waddr = stk_rd;
          par_wdata = {1'b0, i_r};
          stk_re    = dep_gt1;
          stk_raddr = sec_addr;
        end else begin
          c1_nxt  = '0;
          err_nxt = 1'b1;
        end
      end
      ST_POP2: begin
        if (dep_pos) begin
          par_we    = 1'b1;
          par_waddr = stk_rd;
          par_wdata = {1'b0, i_r};
        end else begin
          err_nxt = 1'b1;
        end
        lnk_we    = 1'b1;
        lnk_wdata = {c1_r, c2, 1'b0};
        stk_waddr = IW'(dep_pop);
        if (dep_pop < CW'(MAX_NODES)) begin
          stk_we  = 1'b1;
          dep_nxt = dep_pop + CW'(1);
        end else begin
          err_nxt = 1'b1;
          dep_nxt = dep_pop;
        end
        i_nxt = i_r - IW'(1);
      end
      ST_FIN0: begin
        // node 0 hangs off the main root
        par_we    = 1'b1;
        par_waddr = '0;
        par_wdata = {1'b1, {IW{1'b0}}};
        if (dep_r != CW'(2)) begin
          err_nxt = 1'b1;
        end
        stk_re = dep_pos;
      end
      ST_FIN1: begin
        if (32'(rr_r) < MAX_NODES) begin
          par_we    = 1'b1;
          par_waddr = IW'(rr_r);
          par_wdata = {1'b1, {IW{1'b0}}};
        end
        if (dep_pos) begin
          rl_nxt    = stk_rd;
          dep_nxt   = dep_dec;
          stk_re    = dep_gt1;
          stk_raddr = sec_addr;
        end else begin
          rl_nxt  = '0;
          err_nxt = 1'b1;
        end
      end
      ST_FIN2: begin
        rt_nxt = c2;
        if (dep_pos) begin
          dep_nxt = dep_dec;
        end else begin
          err_nxt = 1'b1;
        end
        e_nxt = '0;
      end
      ST_ERD: begin
        lnk_re = 1'b1;
        par_re = 1'b1;
      end
      ST_ELOAD: begin
        if (out_can) begin
          out_load               = 1'b1;
          out_din.node_index     = 4'(e_r);
          out_din.parent_index   = par_val[3:0];
          out_din.parent_is_root = par_val[ROOT_BIT];
          out_din.left_child     = 4'(lnk_rd[LW-1 -: IW]);
          out_din.right_child    = 4'(lnk_rd[IW:1]);
          out_din.is_leaf        = lnk_rd[0];
          e_nxt                  = e_r + IW'(1);
        end
      end
      ST_RLOAD: begin
        if (out_can) begin
          out_load              = 1'b1;
          out_din.left_child    = 4'(rl_r);
          out_din.right_child   = 4'(rt_r);
          out_din.is_root_entry = 1'b1;
          out_din.malformed     = err_r;
          out_din.last          = 1'b1;
          // start of the next tree
          cnt_nxt = '0;
          dep_nxt = '0;
          err_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_LOAD;
      cnt_r <= '0;
      dep_r <= '0;
      err_r <= 1'b0;
      rr_r  <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      dep_r <= dep_nxt;
      err_r <= err_nxt;
      rr_r  <= rr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r  <= i_nxt;
    c1_r <= c1_nxt;
    rl_r <= rl_nxt;
    rt_r <= rt_nxt;
    e_r  <= e_nxt;
  end

  assign out_node_index     = out_dout.node_index;
  assign out_parent_index   = out_dout.parent_index;
  assign out_parent_is_root = out_dout.parent_is_root;
  assign out_left_child     = out_dout.left_child;
  assign out_right_child    = out_dout.right_child;
  assign out_is_leaf        = out_dout.is_leaf;
  assign out_is_root_entry  = out_dout.is_root_entry;
  assign out_malformed      = out_dout.malformed;
  assign out_last           = out_dout.last;

endmodule

// ----- design/ptlb_ram.sv -----
module ptlb_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/ptlb_out_reg.sv -----
module ptlb_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  ptlb_pkg::res_t  din,
  input  logic            stall,
  output logic            can_load,
  output logic            valid,
  output ptlb_pkg::res_t  dout
);

  import ptlb_pkg::*;

  logic valid_r;
  logic valid_nxt;
  res_t data_r;

  assign can_load = !valid_r || !stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= din;
    end
  end

  assign valid = valid_r;
  assign dout  = data_r;

endmodule

// ----- tb/tree_link_checker.sv -----
`timescale 1ns / 1ps
module tree_link_checker #(
  parameter int MAX_NODES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_node_id,
  input  logic [3:0] in_right_root_index,
  input  logic       in_last_node,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [3:0] out_node_index,
  input  logic [3:0] out_parent_index,
  input  logic       out_parent_is_root,
  input  logic [3:0] out_left_child,
  input  logic [3:0] out_right_child,
  input  logic       out_is_leaf,
  input  logic       out_is_root_entry,
  input  logic       out_malformed,
  input  logic       out_last,
  output int         fail_count,
  output int         pending
);

  import ptlb_pkg::*;

  localparam logic [4:0] ROOT_LINK = 5'b1 << ROOT_BIT;

  kind_t       node_kind [MAX_NODES];
  int unsigned node_total = 0;
  bit          node_overflow = 1'b0;
  logic [3:0]  walk_stack [MAX_NODES];
  int unsigned walk_depth = 0;
  bit          tree_bad = 1'b0;
  res_t        link_fifo [$];

  function automatic void push_entry(logic [3:0] idx);
    if (walk_depth < MAX_NODES) begin
      walk_stack[walk_depth] = idx;
      walk_depth++;
    end else begin
      tree_bad = 1'b1;
    end
  endfunction

  // an empty stack yields index 0 and marks the tree bad
  function automatic bit pop_entry(output logic [3:0] idx);
    if (walk_depth == 0) begin
      tree_bad = 1'b1;
      idx = '0;
      return 1'b0;
    end
    walk_depth--;
    idx = walk_stack[walk_depth];
    return 1'b1;
  endfunction

  function automatic void take_node(logic [7:0] id, logic [3:0] rr, logic fin);
    logic [4:0] up [MAX_NODES];
    logic [3:0] lc [MAX_NODES];
    logic [3:0] rc [MAX_NODES];
    logic       leaf [MAX_NODES];
    logic [3:0] kid;
    logic [3:0] root_l;
    logic [3:0] root_r;
    res_t       r;
    if (node_total < MAX_NODES) begin
      node_kind[node_total] = (id == 8'd0) ? KIND_EMPTY : (id[7] ? KIND_INNER : KIND_LEAF);
      node_total++;
    end else begin
      node_overflow = 1'b1;
    end
    if (!fin) return;

    tree_bad = node_overflow;
    walk_depth = 0;
    for (int k = 0; k < MAX_NODES; k++) begin
      up[k] = '0;
      lc[k] = '0;
      rc[k] = '0;
      leaf[k] = 1'b0;
    end
    // backward walk over the loaded nodes
    for (int i = int'(node_total) - 1; i >= 0; i--) begin
      case (node_kind[i])
        KIND_LEAF: begin
          leaf[i] = 1'b1;
          push_entry(4'(i));
        end
        KIND_INNER: begin
          if (pop_entry(kid)) up[kid] = 5'(i);
          lc[i] = kid;
          if (pop_entry(kid)) up[kid] = 5'(i);
          rc[i] = kid;
          push_entry(4'(i));
        end
        default: ;
      endcase
    end
    up[0] = ROOT_LINK;
    up[rr] = ROOT_LINK;
    if (walk_depth != 2) tree_bad = 1'b1;
    void'(pop_entry(root_l));
    void'(pop_entry(root_r));

    for (int i = 0; i < int'(node_total); i++) begin
      r = '0;
      r.node_index = 4'(i);
      r.parent_index = up[i][3:0];
      r.parent_is_root = up[i][ROOT_BIT];
      r.left_child = lc[i];
      r.right_child = rc[i];
      r.is_leaf = leaf[i];
      link_fifo.push_back(r);
    end
    r = '0;
    r.left_child = root_l;
    r.right_child = root_r;
    r.is_root_entry = 1'b1;
    r.malformed = tree_bad;
    r.last = 1'b1;
    link_fifo.push_back(r);
    node_total = 0;
    node_overflow = 1'b0;
  endfunction

  function automatic int unsigned differs(string field, int unsigned want, int unsigned got);
    if (want == got) return 0;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin : monitor
    int unsigned bad;
    res_t want;
    if (!rst_n) begin
      fail_count <= 0;
      pending <= 0;
      link_fifo.delete();
      node_total = 0;
      node_overflow = 1'b0;
    end else begin
      bad = 0;
      if (out_valid && !out_stall) begin
        if (link_fifo.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual node %0d root %0b",
                   $time, out_node_index, out_is_root_entry);
          bad++;
        end else begin
          want = link_fifo.pop_front();
          bad += differs("node_index", want.node_index, out_node_index);
          bad += differs("parent_index", want.parent_index, out_parent_index);
          bad += differs("parent_is_root", want.parent_is_root, out_parent_is_root);
          bad += differs("left_child", want.left_child, out_left_child);
          bad += differs("right_child", want.right_child, out_right_child);
          bad += differs("is_leaf", want.is_leaf, out_is_leaf);
          bad += differs("is_root_entry", want.is_root_entry, out_is_root_entry);
          bad += differs("malformed", want.malformed, out_malformed);
          bad += differs("last", want.last, out_last);
        end
      end
      if (in_valid && !in_stall) take_node(in_node_id, in_right_root_index, in_last_node);
      fail_count <= fail_count + int'(bad);
      pending <= link_fifo.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import ptlb_pkg::*;

  localparam int TREE_CAP     = 16;
  localparam int RESET_CYCLES = 12;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int TAIL_CYCLES  = 100;   // settle time once nothing is outstanding
  localparam int IDLE_LIMIT   = 4000;  // watchdog: cycles with no request moving
  localparam int ITEM_TARGET  = 170;
  localparam int QUIET_FROM   = 140;   // no idling from here on

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_node_id = '0;
  logic [3:0] in_right_root_index = '0;
  logic       in_last_node = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [3:0] out_node_index;
  logic [3:0] out_parent_index;
  logic       out_parent_is_root;
  logic [3:0] out_left_child;
  logic [3:0] out_right_child;
  logic       out_is_leaf;
  logic       out_is_root_entry;
  logic       out_malformed;
  logic       out_last;
  int         fail_count;
  int         pending;

  // stimulus state
  logic [7:0]  tree_q [$];     // preorder ids of the tree being offered
  int unsigned items_sent = 0;
  bit          tx_idle_on = 1'b0;
  bit          rx_idle_on = 1'b0;
  int unsigned hold_ask = 0;   // bumped to ask the receiver for a long hold-off
  int unsigned idle_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  preorder_tree_link_builder #(.MAX_NODES(TREE_CAP)) u_top (.*);

  tree_link_checker #(.MAX_NODES(TREE_CAP)) u_check (.*);

  // node id generators: mostly within the usual range, now and then out to the field limits
  function automatic logic [7:0] inner_id();
    return 8'(-int'($urandom_range(1, ($urandom_range(0, 7) == 0) ? 128 : 64)));
  endfunction

  function automatic logic [7:0] leaf_id();
    return 8'($urandom_range(1, ($urandom_range(0, 7) == 0) ? 127 : 64));
  endfunction

  // appends a random full binary subtree in preorder; an inner node is forced
  // whenever placing a leaf would close the subtree too early
  function automatic void grow_tree(int unsigned leaves);
    int unsigned inner_left;
    int unsigned leaf_left;
    inner_left = leaves - 1;
    leaf_left = leaves;
    while (leaf_left > 0) begin
      if (inner_left > 0 && (leaf_left - inner_left == 1 || $urandom_range(0, 1) == 1)) begin
        tree_q.push_back(inner_id());
        inner_left--;
      end else begin
        tree_q.push_back(leaf_id());
        leaf_left--;
      end
    end
  endfunction

  // offers every id of tree_q, the right-subtree root riding on the last one;
  // valid stays high after the final request so the next tree follows without a gap
  task automatic send_tree(logic [3:0] rr);
    for (int k = 0; k < tree_q.size(); k++) begin
      if (tx_idle_on && $urandom_range(0, 4) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_node_id <= tree_q[k];
      in_last_node <= (k == tree_q.size() - 1);
      in_right_root_index <= (k == tree_q.size() - 1) ? rr : 4'($urandom);
      do @(posedge clk); while (in_stall);
      items_sent++;
    end
    tree_q.delete();
  endtask

  // sender goes quiet until every outstanding result has been seen
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // receiver: random stall bursts, plus one long hold-off when asked
  initial begin : receiver
    int unsigned hold_seen;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: any stretch with no request moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time, pending);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned left_leaves;
    logic [3:0]  rr;
    bit          paused;
    bit          held;
    paused = 1'b0;
    held = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_on = 1'b1;
    rx_idle_on <= 1'b1;

    // lone inner node: both pops underflow
    tree_q = '{8'h80};
    send_tree(4'd0);
    // well-formed pair of subtrees, ids at the field extremes
    tree_q = '{8'hc0, 8'h7f, 8'h01, 8'h40};
    send_tree(4'd3);
    // empty slot without a parent, right root past the loaded nodes, single final entry
    tree_q = '{8'hfb, 8'h00, 8'h01, 8'h02};
    send_tree(4'd15);
    // one node too many: the extra id is dropped and the stack ends sixteen deep
    for (int k = 0; k < TREE_CAP + 1; k++) tree_q.push_back(8'(k + 1));
    send_tree(4'd8);

    // random trees, mostly two well-formed subtrees side by side
    while (items_sent < ITEM_TARGET) begin
      tx_idle_on = items_sent < QUIET_FROM && $urandom_range(0, 3) != 0;
      rx_idle_on <= items_sent < QUIET_FROM && $urandom_range(0, 3) != 0;
      if (!paused && items_sent >= 40) begin
        drain_results();
        paused = 1'b1;
      end
      if (!held && items_sent >= 80) begin
        // receiver holds off while further trees keep coming, so the block backs up
        hold_ask <= hold_ask + 1;
        held = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        left_leaves = $urandom_range(1, 7);
        grow_tree(left_leaves);
        rr = 4'(tree_q.size());
        grow_tree($urandom_range(1, 9 - left_leaves));
      end else if (pick < 9) begin
        // broken sequence: any mix of ids, sometimes longer than the node limit
        repeat ($urandom_range(1, TREE_CAP + 2)) begin
          case ($urandom_range(0, 3))
            0:       tree_q.push_back(8'd0);
            1:       tree_q.push_back(leaf_id());
            2:       tree_q.push_back(inner_id());
            default: tree_q.push_back(8'($urandom));
          endcase
        end
        rr = 4'($urandom);
      end else begin
        // single subtree with a right root picked at random
        grow_tree($urandom_range(1, 8));
        rr = 4'($urandom);
      end
      send_tree(rr);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- preorder_tree_link_builder.f -----
design/ptlb_pkg.sv
design/ptlb_ram.sv
design/ptlb_out_reg.sv
design/preorder_tree_link_builder.sv
tb/tree_link_checker.sv
tb/testbench.sv
